// ===== hw/rtl/gprbd_pkg.sv =====
// shared types, constants and the hat table of the gamepad report button decoder
package gprbd_pkg;

	// report length counter saturates here
	localparam int unsigned MaxReportBytes = 1023;
	localparam int unsigned CntW           = $clog2(MaxReportBytes + 1);
	localparam int unsigned CapDepth       = 13;
	localparam int unsigned MaskW          = 13;
	localparam int unsigned OutDataW       = ((3 * MaskW + 7) / 8) * 8;

	// report ids
	localparam logic [7:0] ID_USB     = 8'h01;
	localparam logic [7:0] ID_BT_OLD  = 8'h11;
	localparam logic [7:0] ID_BT_NEW  = 8'h31;

	// button bit positions
	localparam int unsigned B_HOME  = 8;
	localparam int unsigned B_UP    = 9;
	localparam int unsigned B_RIGHT = 10;
	localparam int unsigned B_DOWN  = 11;
	localparam int unsigned B_LEFT  = 12;

	// register reset values
	localparam logic       RST_PAD_LAYOUT   = 1'b0;
	localparam logic [7:0] RST_STICK_CENTER = 8'd128;
	localparam logic [6:0] RST_ENTER_OFFSET = 7'd60;
	localparam logic [6:0] RST_LEAVE_OFFSET = 7'd30;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_PAD_LAYOUT   = 2'd0,
		CFG_STICK_CENTER = 2'd1,
		CFG_ENTER_OFFSET = 2'd2,
		CFG_LEAVE_OFFSET = 2'd3
	} gprbd_cfg_idx_t;

	// button block start byte
	typedef enum logic [1:0] {
		BASE_5  = 2'd0,
		BASE_7  = 2'd1,
		BASE_8  = 2'd2,
		BASE_10 = 2'd3
	} gprbd_base_t;

	typedef struct packed {
		logic                   pad_layout;
		logic [7:0]             stick_center;
		logic [6:0]             enter_offset;
		logic [6:0]             leave_offset;
	} gprbd_cfg_t;

	// staged beat as seen by the decoder, with the current byte merged in
	typedef struct packed {
		logic                        valid;
		logic                        last;
		logic [CntW-1:0]             len;
		logic [CapDepth-1:0][7:0]    bytes;
	} gprbd_item_t;

	// hat nibble to d-pad bits
	function automatic logic [MaskW-1:0] hat_bits(input logic [3:0] hat);
		logic [MaskW-1:0] m;
		m = '0;
		case (hat)
			4'd0: m[B_UP] = 1'b1;
			4'd1: begin
				m[B_UP]    = 1'b1;
				m[B_RIGHT] = 1'b1;
			end
			4'd2: m[B_RIGHT] = 1'b1;
			4'd3: begin
				m[B_DOWN]  = 1'b1;
				m[B_RIGHT] = 1'b1;
			end
			4'd4: m[B_DOWN] = 1'b1;
			4'd5: begin
				m[B_DOWN] = 1'b1;
				m[B_LEFT] = 1'b1;
			end
			4'd6: m[B_LEFT] = 1'b1;
			4'd7: begin
				m[B_UP]   = 1'b1;
				m[B_LEFT] = 1'b1;
			end
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

// ===== hw/rtl/gamepad_report_button_decoder_top.sv =====
// top level of the gamepad report button decoder: configuration registers and stages
// the last beat of a valid report passes the beat register, then the result register
// throughput: one report byte per cycle; the beat register holds one beat while a
// result waits, so the input stalls only when the result register is full and not taken
// reset: arst_n clears the byte count, stick and emitted masks, valid flags and config
// registers to their defaults; the capture store, beat data and result masks are not reset
module gamepad_report_button_decoder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,    // report_byte
	input  logic                            s_tlast,    // last_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gprbd_pkg::OutDataW-1:0]  m_tdata,    // button_mask, pressed_mask, released_mask
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [7:0]                      cfg_data
);
	import gprbd_pkg::*;

	gprbd_cfg_t   cfg_q;
	gprbd_item_t  item;
	logic         take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pad_layout   <= RST_PAD_LAYOUT;
			cfg_q.stick_center <= RST_STICK_CENTER;
			cfg_q.enter_offset <= RST_ENTER_OFFSET;
			cfg_q.leave_offset <= RST_LEAVE_OFFSET;
		end else if (cfg_we) begin
			unique case (gprbd_cfg_idx_t'(cfg_index))
				CFG_PAD_LAYOUT:   cfg_q.pad_layout   <= cfg_data[0];
				CFG_STICK_CENTER: cfg_q.stick_center <= cfg_data;
				CFG_ENTER_OFFSET: cfg_q.enter_offset <= cfg_data[6:0];
				CFG_LEAVE_OFFSET: cfg_q.leave_offset <= cfg_data[6:0];
			endcase
		end
	end

	// input stage
	gprbd_capture u_capture (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.take     (take),
		.item     (item)
	);

	// decode and result stage
	gprbd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg      (cfg_q),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== hw/rtl/gprbd_capture.sv =====
// input stage: beat register, byte counter and capture of the first report bytes
module gprbd_capture (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // report_byte
	input  logic                   s_tlast,   // last_byte
	input  logic                   take,
	output gprbd_pkg::gprbd_item_t item
);
	import gprbd_pkg::*;

	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic                      last_s1;
	logic [CntW-1:0]           count_q;
	logic [CapDepth-1:0][7:0]  cap_q;
	logic                      fire;

	assign fire     = valid_s1 && take;
	assign s_tready = !valid_s1 || take;

	// beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// byte count, cleared at the end of each report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			if (last_s1) begin
				count_q <= '0;
			end else if (count_q != CntW'(MaxReportBytes)) begin
				count_q <= count_q + CntW'(1);
			end
		end
	end

	// capture store, no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < CapDepth; i++) begin
			if (fire && count_q == CntW'(i)) begin
				cap_q[i] <= byte_s1;
			end
		end
	end

	// view of the report including the byte in flight
	always_comb begin
		item.valid = valid_s1;
		item.last  = last_s1;
		item.len   = (count_q == CntW'(MaxReportBytes)) ? count_q : count_q + CntW'(1);
		for (int i = 0; i < CapDepth; i++) begin
			item.bytes[i] = (count_q == CntW'(i)) ? byte_s1 : cap_q[i];
		end
	end

	// a stalled beat stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("staged beat lost while stalled");

	// a finished report restarts the count
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> count_q == '0)
		else $error("byte count not cleared after last beat");

endmodule

// ===== hw/rtl/gprbd_decode.sv =====
// report decode: button block select, stick hysteresis, press/release masks, result register
module gprbd_decode (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gprbd_pkg::gprbd_item_t          item,
	input  gprbd_pkg::gprbd_cfg_t           cfg,
	output logic                            take,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gprbd_pkg::OutDataW-1:0]  m_tdata    // button_mask, pressed_mask, released_mask
);
	import gprbd_pkg::*;

	// one axis: returns {hi, lo}
	function automatic logic [1:0] axis_dir(input logic [7:0] v, input logic [7:0] c,
			input logic [6:0] en, input logic [6:0] lv, input logic was_hi,
			input logic was_lo);
		logic [8:0] hi_thr;
		logic [8:0] lo_sum;
		logic       hi;
		logic       lo;
		hi_thr = {1'b0, c} + {2'b0, (was_hi ? lv : en)};
		lo_sum = {1'b0, v} + {2'b0, (was_lo ? lv : en)};
		hi     = {1'b0, v} > hi_thr;
		lo     = !hi && (lo_sum < {1'b0, c});
		return {hi, lo};
	endfunction

	logic                fire;
	logic                id_ok;
	logic                res_ok;
	gprbd_base_t         base_sel;
	logic [CntW-1:0]     need_len;
	logic [7:0]          b0, b1, b2, ax, ay;
	logic [1:0]          dx, dy;
	logic [MaskW-1:0]    stick;
	logic [MaskW-1:0]    btn;
	logic [MaskW-1:0]    stick_q;
	logic [MaskW-1:0]    emitted_q;
	logic [MaskW-1:0]    button_q, pressed_q, released_q;

	assign take = !m_tvalid || m_tready;
	assign fire = item.valid && take;

	// find the button block from id, layout and length
	always_comb begin
		id_ok    = 1'b1;
		base_sel = BASE_5;
		if (item.bytes[0] == ID_USB) begin
			base_sel = (cfg.pad_layout || item.len < CntW'(11)) ? BASE_5 : BASE_8;
		end else if (item.bytes[0] == ID_BT_OLD && cfg.pad_layout) begin
			base_sel = BASE_7;
		end else if (item.bytes[0] == ID_BT_NEW && !cfg.pad_layout) begin
			base_sel = BASE_10;
		end else begin
			id_ok = 1'b0;
		end
	end

	// fixed byte selection per block position
	always_comb begin
		unique case (base_sel)
			BASE_5: begin
				b0 = item.bytes[5]; b1 = item.bytes[6]; b2 = item.bytes[7];
				ax = item.bytes[1]; ay = item.bytes[2];
				need_len = CntW'(8);
			end
			BASE_7: begin
				b0 = item.bytes[7]; b1 = item.bytes[8]; b2 = item.bytes[9];
				ax = item.bytes[1]; ay = item.bytes[2];
				need_len = CntW'(10);
			end
			BASE_8: begin
				b0 = item.bytes[8]; b1 = item.bytes[9]; b2 = item.bytes[10];
				ax = item.bytes[1]; ay = item.bytes[2];
				need_len = CntW'(11);
			end
			BASE_10: begin
				b0 = item.bytes[10]; b1 = item.bytes[11]; b2 = item.bytes[12];
				ax = item.bytes[3]; ay = item.bytes[4];
				need_len = CntW'(13);
			end
		endcase
	end

	assign res_ok = item.last && id_ok && (item.len >= need_len);

	// stick hysteresis and button assembly
	always_comb begin
		dx    = axis_dir(ax, cfg.stick_center, cfg.enter_offset, cfg.leave_offset,
			stick_q[B_RIGHT], stick_q[B_LEFT]);
		dy    = axis_dir(ay, cfg.stick_center, cfg.enter_offset, cfg.leave_offset,
			stick_q[B_DOWN], stick_q[B_UP]);
		stick          = '0;
		stick[B_RIGHT] = dx[1];
		stick[B_LEFT]  = dx[0];
		stick[B_DOWN]  = dy[1];
		stick[B_UP]    = dy[0];
		btn            = '0;
		btn[3:0]       = b0[7:4];
		btn[5:4]       = b1[1:0];
		btn[7:6]       = b1[5:4];
		btn[B_HOME]    = b2[0];
		btn            = btn | hat_bits(b0[3:0]) | stick;
	end

	// stick and emitted state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_q   <= '0;
			emitted_q <= '0;
		end else if (fire && res_ok) begin
			stick_q   <= stick;
			emitted_q <= btn;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (fire && res_ok) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_ok) begin
			button_q   <= btn;
			pressed_q  <= btn & ~emitted_q;
			released_q <= ~btn & emitted_q;
		end
	end

	assign m_tdata = {{(OutDataW - 3 * MaskW){1'b0}}, released_q, pressed_q, button_q};

	// a button cannot be pressed and released in one result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pressed_q & released_q) == '0)
		else $error("pressed and released masks overlap");

	// opposite stick directions never held together
	assert property (@(posedge clk) disable iff (!arst_n)
		!(stick_q[B_RIGHT] && stick_q[B_LEFT]) && !(stick_q[B_UP] && stick_q[B_DOWN]))
		else $error("opposite stick directions both active");

	// the emitted mask tracks the result just loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_ok |=> m_tvalid && emitted_q == button_q)
		else $error("emitted mask out of step with result");

endmodule

// ===== sim/tb_gamepad_report_button_decoder_top.sv =====
// testbench for the gamepad report button decoder: directed and random reports, self-checking
`timescale 1ns / 1ps

module tb_gamepad_report_button_decoder_top;
	import gprbd_pkg::*;

	localparam int unsigned STALL_LIMIT   = 1000;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned HOLD_CYCLES   = 64;
	localparam int unsigned PHASE_BEATS   = 60;

	// one decoded result, laid out as on m_tdata
	typedef struct packed {
		logic [MaskW-1:0] released;
		logic [MaskW-1:0] pressed;
		logic [MaskW-1:0] held;
	} button_report_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata   = 8'h00;
	logic                s_tlast   = 1'b0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_we    = 1'b0;
	logic [1:0]          cfg_index = CFG_PAD_LAYOUT;
	logic [7:0]          cfg_data  = 8'h00;

	// decoder copy: configuration and report state
	gprbd_cfg_t       pad_cfg;
	int unsigned      rx_count;
	logic [7:0]       rx_bytes [CapDepth];
	logic [MaskW-1:0] stick_dirs;
	logic [MaskW-1:0] last_emitted;

	button_report_t   expected_buttons [$];
	logic [7:0]       report_buf [$];
	int unsigned      beats_sent;
	int unsigned      mismatches;
	int unsigned      stall_cycles;
	bit               gaps_on;
	bit               stalls_on;
	bit               hold_off_req;

	gamepad_report_button_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// one stick axis with enter and leave hysteresis; high direction wins
	function automatic logic [MaskW-1:0] axis_dirs(input int v, input logic [MaskW-1:0] prev,
			input int hi, input int lo);
		int c;
		int en;
		int lv;
		logic [MaskW-1:0] r;
		c  = pad_cfg.stick_center;
		en = pad_cfg.enter_offset;
		lv = pad_cfg.leave_offset;
		r  = '0;
		if (prev[hi] ? (v > c + lv) : (v > c + en))
			r[hi] = 1'b1;
		else if (prev[lo] ? (v < c - lv) : (v < c - en))
			r[lo] = 1'b1;
		return r;
	endfunction

	// capture one accepted beat and, at the end of a valid report, queue its masks
	function automatic void predict_beat(input logic [7:0] data, input logic is_last);
		int unsigned      len;
		int unsigned      base;
		int unsigned      ax;
		logic [7:0]       b0;
		logic [7:0]       b1;
		logic [7:0]       b2;
		logic [MaskW-1:0] held;
		logic [MaskW-1:0] dirs;
		logic [MaskW-1:0] changed;
		button_report_t   want;
		if (rx_count < CapDepth)
			rx_bytes[rx_count] = data;
		if (rx_count < MaxReportBytes)
			rx_count++;
		if (!is_last)
			return;
		len      = rx_count;
		rx_count = 0;

		// button block position from id, layout and length
		if (rx_bytes[0] == ID_USB)
			base = (pad_cfg.pad_layout || len < 11) ? 5 : 8;
		else if (rx_bytes[0] == ID_BT_OLD && pad_cfg.pad_layout)
			base = 7;
		else if (rx_bytes[0] == ID_BT_NEW && !pad_cfg.pad_layout)
			base = 10;
		else
			return;
		if (len < base + 3)
			return;

		b0 = rx_bytes[base];
		b1 = rx_bytes[base + 1];
		b2 = rx_bytes[base + 2];
		held         = '0;
		held[3:0]    = b0[7:4];
		held[5:4]    = b1[1:0];
		held[7:6]    = b1[5:4];
		held[B_HOME] = b2[0];

		// eight-way hat, values above 7 are centred
		case (b0[3:0])
			4'd0: held[B_UP] = 1'b1;
			4'd1: {held[B_UP], held[B_RIGHT]} = 2'b11;
			4'd2: held[B_RIGHT] = 1'b1;
			4'd3: {held[B_DOWN], held[B_RIGHT]} = 2'b11;
			4'd4: held[B_DOWN] = 1'b1;
			4'd5: {held[B_DOWN], held[B_LEFT]} = 2'b11;
			4'd6: held[B_LEFT] = 1'b1;
			4'd7: {held[B_UP], held[B_LEFT]} = 2'b11;
			default: ;
		endcase

		// left stick merged into the d-pad bits
		ax   = (base >= 8) ? base - 7 : 1;
		dirs = axis_dirs(rx_bytes[ax], stick_dirs, B_RIGHT, B_LEFT)
			| axis_dirs(rx_bytes[ax + 1], stick_dirs, B_DOWN, B_UP);
		stick_dirs = dirs;
		held       = held | dirs;

		changed       = held ^ last_emitted;
		want.held     = held;
		want.pressed  = changed & held;
		want.released = changed & last_emitted;
		last_emitted  = held;
		expected_buttons.push_back(want);
	endfunction

	// stick byte, mostly near the hysteresis thresholds
	function automatic logic [7:0] stick_sample();
		int c;
		int v;
		c = pad_cfg.stick_center;
		case ($urandom_range(0, 5))
			0: v = c + int'(pad_cfg.enter_offset) + int'($urandom_range(0, 2)) - 1;
			1: v = c - int'(pad_cfg.enter_offset) + int'($urandom_range(0, 2)) - 1;
			2: v = c + int'(pad_cfg.leave_offset) + int'($urandom_range(0, 2)) - 1;
			3: v = c - int'(pad_cfg.leave_offset) + int'($urandom_range(0, 2)) - 1;
			4: v = c;
			default: v = $urandom_range(0, 255);
		endcase
		if (v < 0 || v > 255)
			v = $urandom_range(0, 255);
		return v[7:0];
	endfunction

	function automatic void fill_report(input logic [7:0] id, input int len);
		report_buf.delete();
		report_buf.push_back(id);
		for (int i = 1; i < len; i++)
			report_buf.push_back((i <= 4) ? stick_sample() : 8'($urandom));
	endfunction

	// one beat on the input, with an optional gap first
	task automatic send_beat(input logic [7:0] data, input logic is_last);
		int gap;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= is_last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_beat(data, is_last);
		beats_sent++;
	endtask

	task automatic send_report();
		for (int i = 0; i < report_buf.size(); i++)
			send_beat(report_buf[i], i == report_buf.size() - 1);
	endtask

	// drop valid, wait for every result and let a report with no result finish
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_buttons.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all four registers, spare data bits filled at random
	task automatic set_config(input logic layout, input logic [7:0] center,
			input logic [6:0] enter, input logic [6:0] leave);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PAD_LAYOUT;
		cfg_data  <= {7'($urandom), layout};
		@(posedge clk);
		pad_cfg.pad_layout = layout;
		cfg_index <= CFG_STICK_CENTER;
		cfg_data  <= center;
		@(posedge clk);
		pad_cfg.stick_center = center;
		cfg_index <= CFG_ENTER_OFFSET;
		cfg_data  <= {1'($urandom), enter};
		@(posedge clk);
		pad_cfg.enter_offset = enter;
		cfg_index <= CFG_LEAVE_OFFSET;
		cfg_data  <= {1'($urandom), leave};
		@(posedge clk);
		pad_cfg.leave_offset = leave;
		cfg_we <= 1'b0;
	endtask

	// well-formed reports with random content, plus cut-short and noise reports
	task automatic send_random_report();
		logic [7:0] id;
		int         len;
		case ($urandom_range(0, 9))
			8: begin
				id  = $urandom_range(0, 1) ? ID_USB : ($urandom_range(0, 1) ? ID_BT_OLD : ID_BT_NEW);
				len = $urandom_range(1, 12);
			end
			9: begin
				id  = 8'($urandom);
				len = $urandom_range(1, 20);
			end
			default: begin
				if (pad_cfg.pad_layout)
					id = $urandom_range(0, 1) ? ID_USB : ID_BT_OLD;
				else
					id = $urandom_range(0, 1) ? ID_USB : ID_BT_NEW;
				case (id)
					ID_USB:    len = $urandom_range(8, 16);
					ID_BT_OLD: len = $urandom_range(10, 16);
					default:   len = $urandom_range(13, 20);
				endcase
				if ($urandom_range(0, 15) == 0)
					len += $urandom_range(1, 40);
			end
		endcase
		fill_report(id, len);
		send_report();
	endtask

	// reset settings: both id layouts of the newer pad, bad id, short report, no change
	task automatic test_directed_decode();
		report_buf = '{8'h01, 8'h80, 8'h80, 8'h00, 8'h00, 8'hF0, 8'h33, 8'h01};
		send_report();
		report_buf = '{8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h08, 8'h00, 8'h00};
		send_report();
		report_buf = '{8'h02};
		send_report();
		report_buf = '{8'h31, 8'h00, 8'h00, 8'hA0, 8'hC0, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h07, 8'hCC, 8'hFE};
		send_report();
		send_report();
		void'(report_buf.pop_back());
		send_report();
		report_buf = '{8'h11, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
			8'hFF, 8'hFF};
		send_report();
		wait_idle();
	endtask

	// older pad: its own id, the short block position for the first id, other id refused
	task automatic test_older_layout();
		set_config(1'b1, 8'd128, 7'd60, 7'd30);
		report_buf = '{8'h11, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5F,
			8'h30, 8'h01};
		send_report();
		report_buf = '{8'h01, 8'h80, 8'h80, 8'h00, 8'h00, 8'h12, 8'h03, 8'h00,
			8'h00, 8'h00, 8'h00};
		send_report();
		report_buf = '{8'h31, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h44, 8'h11, 8'h01};
		send_report();
		wait_idle();
	endtask

	// report longer than the byte counter can hold
	task automatic test_long_report();
		set_config(1'b0, 8'd128, 7'd60, 7'd30);
		fill_report(ID_USB, MaxReportBytes + 7);
		send_report();
		fill_report(ID_USB, 11);
		send_report();
		wait_idle();
	endtask

	// random reports across several register settings, extremes included
	task automatic test_random_settings();
		int unsigned target;
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			case (p)
				0: set_config(1'b1, 8'd128, 7'd60, 7'd30);
				1: set_config(1'b0, 8'd0, 7'd0, 7'd0);
				2: set_config(1'b1, 8'd255, 7'd127, 7'd127);
				3: set_config(1'b0, 8'd100, 7'd20, 7'd50);
				default: set_config(1'($urandom), 8'($urandom), 7'($urandom), 7'($urandom));
			endcase
			target = beats_sent + PHASE_BEATS;
			while (beats_sent < target)
				send_random_report();
		end
		wait_idle();
	endtask

	// receiver holds off while short valid reports keep coming
	task automatic test_output_backpressure();
		set_config(1'b0, 8'd128, 7'd60, 7'd30);
		gaps_on      = 1'b0;
		hold_off_req = 1'b1;
		repeat (16) begin
			fill_report(ID_USB, 8);
			send_report();
		end
		wait_idle();
		gaps_on = 1'b1;
	endtask

	// full rate on both sides to the end
	task automatic test_steady_stream();
		int unsigned target;
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		target    = beats_sent + 200;
		while (beats_sent < target)
			send_random_report();
		wait_idle();
	endtask

	// receiver: ready runs, stall bursts and the long hold-off
	initial begin
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// result check against the oldest expected masks
	always @(posedge clk) begin : result_check
		button_report_t got;
		button_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[3 * MaskW - 1:0];
			if (expected_buttons.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: held %h pressed %h released %h",
						got.held, got.pressed, got.released);
			end else begin
				want = expected_buttons.pop_front();
				if (got.held !== want.held || got.pressed !== want.pressed
						|| got.released !== want.released) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: held %h/%h pressed %h/%h released %h/%h (exp/act)",
							want.held, got.held, want.pressed, got.pressed,
							want.released, got.released);
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		pad_cfg      = '{RST_PAD_LAYOUT, RST_STICK_CENTER, RST_ENTER_OFFSET, RST_LEAVE_OFFSET};
		rx_count     = 0;
		stick_dirs   = '0;
		last_emitted = '0;
		beats_sent   = 0;
		mismatches   = 0;
		stall_cycles = 0;
		gaps_on      = 1'b1;
		stalls_on    = 1'b1;
		hold_off_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_decode();
		test_older_layout();
		test_long_report();
		test_random_settings();
		test_output_backpressure();
		test_steady_stream();

		if (mismatches == 0 && expected_buttons.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== gamepad_report_button_decoder_top.f =====
hw/rtl/gprbd_pkg.sv
hw/rtl/gprbd_capture.sv
hw/rtl/gprbd_decode.sv
hw/rtl/gamepad_report_button_decoder_top.sv
sim/tb_gamepad_report_button_decoder_top.sv
